### design/pse_pkg.sv
// shared types and constants for the postfix stack evaluator
// no dependencies

package pse_pkg;

  localparam int DataW           = 32;
  localparam int SymW            = 8;
  localparam int DefStackDepth   = 32;
  localparam int DivSteps        = DataW;
  localparam int DivCntW         = $clog2(DivSteps + 1);

  localparam logic [SymW-1:0] SymZero  = 8'h30;
  localparam logic [SymW-1:0] SymNine  = 8'h39;
  localparam logic [SymW-1:0] SymMul   = 8'h2a;
  localparam logic [SymW-1:0] SymDiv   = 8'h2f;
  localparam logic [SymW-1:0] SymMod   = 8'h25;
  localparam logic [SymW-1:0] SymAdd   = 8'h2b;
  localparam logic [SymW-1:0] SymSub   = 8'h2d;
  localparam logic [SymW-1:0] SymAnd   = 8'h26;
  localparam logic [SymW-1:0] SymOr    = 8'h7c;
  localparam logic [SymW-1:0] SymXor   = 8'h5e;
  localparam logic [SymW-1:0] SymShl   = 8'h6c;
  localparam logic [SymW-1:0] SymShr   = 8'h72;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZ    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    push;
    logic    rd_req;
    logic    alu_wr;
    logic    div_start;
    logic    div_wr;
    logic    flag;
    status_e flag_code;
    logic    out_load;
  } pse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_divop;
    logic full;
    logic lt2;
    logic rhs_zero;
    logic div_done;
  } pse_sts_t;

  function automatic logic is_operator(input logic [SymW-1:0] c);
    return (c == SymMul) || (c == SymDiv) || (c == SymMod) || (c == SymAdd) ||
           (c == SymSub) || (c == SymAnd) || (c == SymOr) || (c == SymXor) ||
           (c == SymShl) || (c == SymShr);
  endfunction

endpackage

### design/pse_div.sv
// iterative radix-2 signed divider, one quotient bit per cycle
// depends on pse_pkg

module pse_div import pse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             want_rem_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [DataW-1:0] result_o
);

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [DataW-1:0]   quo_q, quo_d;
  logic [DataW-1:0]   rem_q, rem_d;
  logic [DataW-1:0]   mb_q, mb_d;
  logic               neg_q_q, neg_q_d;
  logic               neg_r_q, neg_r_d;
  logic               rem_sel_q, rem_sel_d;
  logic [DataW:0]     rem_sh;
  logic [DataW:0]     diff;
  logic [DataW-1:0]   ma, mb;

  assign ma     = dividend_i[DataW-1] ? (DataW'(0) - dividend_i) : dividend_i;
  assign mb     = divisor_i[DataW-1] ? (DataW'(0) - divisor_i) : divisor_i;
  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign diff   = rem_sh - {1'b0, mb_q};

  always_comb begin
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    quo_d     = quo_q;
    rem_d     = rem_q;
    mb_d      = mb_q;
    neg_q_d   = neg_q_q;
    neg_r_d   = neg_r_q;
    rem_sel_d = rem_sel_q;
    if (start_i) begin
      cnt_d     = DivCntW'(DivSteps);
      quo_d     = ma;
      rem_d     = '0;
      mb_d      = mb;
      neg_q_d   = dividend_i[DataW-1] ^ divisor_i[DataW-1];
      neg_r_d   = dividend_i[DataW-1];
      rem_sel_d = want_rem_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - DivCntW'(1);
      if (!diff[DataW]) begin
        rem_d = diff[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      if (cnt_q == DivCntW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    mb_q      <= mb_d;
    neg_q_q   <= neg_q_d;
    neg_r_q   <= neg_r_d;
    rem_sel_q <= rem_sel_d;
  end

  assign done_o = done_q;

  always_comb begin
    if (rem_sel_q) begin
      result_o = neg_r_q ? (DataW'(0) - rem_q) : rem_q;
    end else begin
      result_o = neg_q_q ? (DataW'(0) - quo_q) : quo_q;
    end
  end

endmodule

### design/pse_dpath.sv
// datapath: operand stack memory, top-of-stack register, alu, divider, result beat
// depends on pse_pkg and pse_div

module pse_dpath import pse_pkg::*; #(
  parameter int StackDepth = DefStackDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SymW-1:0]  symbol_i,
  input  logic             last_i,
  input  pse_cmd_t         cmd_i,
  output pse_sts_t         sts_o,
  output logic [DataW-1:0] value_o,
  output logic [2:0]       status_o,
  output logic             done_res_o
);

  localparam int AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int LW = $clog2(StackDepth + 1);
  localparam logic [LW-1:0] DepthL = LW'(StackDepth);

  logic [DataW-1:0] mem_q [StackDepth];
  logic [DataW-1:0] rdata_q;
  logic [DataW-1:0] tos_q;
  logic [LW-1:0]    level_q;
  status_e          err_q;
  logic [SymW-1:0]  sym_q;
  logic             last_q;
  logic [DataW-1:0] value_q;
  logic [2:0]       status_q;
  logic             done_q;
  logic [LW-1:0]    waddr, raddr;
  logic [DataW-1:0] alu_res;
  logic [DataW-1:0] div_res;
  logic             div_done;

  assign waddr = level_q - LW'(1);
  assign raddr = level_q - LW'(2);

  // the memory holds every entry below the top of stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (level_q != '0)) begin
      mem_q[waddr[AW-1:0]] <= tos_q;
    end
    if (cmd_i.rd_req) begin
      rdata_q <= mem_q[raddr[AW-1:0]];
    end
  end

  always_comb begin
    unique case (sym_q)
      SymMul:  alu_res = rdata_q * tos_q;
      SymAdd:  alu_res = rdata_q + tos_q;
      SymSub:  alu_res = rdata_q - tos_q;
      SymAnd:  alu_res = rdata_q & tos_q;
      SymOr:   alu_res = rdata_q | tos_q;
      SymXor:  alu_res = rdata_q ^ tos_q;
      SymShl:  alu_res = rdata_q << tos_q[4:0];
      default: alu_res = DataW'($signed(rdata_q) >>> tos_q[4:0]);
    endcase
  end

  pse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .want_rem_i (sym_q == SymMod),
    .dividend_i (rdata_q),
    .divisor_i  (tos_q),
    .done_o     (div_done),
    .result_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      err_q   <= ST_OK;
    end else begin
      if (cmd_i.out_load && last_q) begin
        level_q <= '0;
        err_q   <= ST_OK;
      end else begin
        if (cmd_i.push) begin
          level_q <= level_q + LW'(1);
        end else if (cmd_i.alu_wr || cmd_i.div_wr) begin
          level_q <= level_q - LW'(1);
        end
        if (cmd_i.flag && (err_q == ST_OK)) begin
          err_q <= cmd_i.flag_code;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sym_q  <= symbol_i;
      last_q <= last_i;
    end
    if (cmd_i.push) begin
      tos_q <= DataW'(sym_q - SymZero);
    end else if (cmd_i.alu_wr) begin
      tos_q <= alu_res;
    end else if (cmd_i.div_wr) begin
      tos_q <= div_res;
    end
    if (cmd_i.out_load) begin
      value_q  <= (level_q != '0) ? tos_q : '0;
      status_q <= err_q;
      done_q   <= last_q;
    end
  end

  assign sts_o.is_digit = (sym_q >= SymZero) && (sym_q <= SymNine);
  assign sts_o.is_op    = is_operator(sym_q);
  assign sts_o.is_divop = (sym_q == SymDiv) || (sym_q == SymMod);
  assign sts_o.full     = (level_q == DepthL);
  assign sts_o.lt2      = (level_q < LW'(2));
  assign sts_o.rhs_zero = (tos_q == '0);
  assign sts_o.div_done = div_done;

  assign value_o    = value_q;
  assign status_o   = status_q;
  assign done_res_o = done_q;

endmodule

### design/pse_ctrl.sv
// controller state machine: sequences decode, stack read, alu or divide, result beat
// depends on pse_pkg

module pse_ctrl import pse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  pse_sts_t sts_i,
  output pse_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_DIVW,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.flag_code = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FIN;
        if (sts_i.is_digit) begin
          if (sts_i.full) begin
            cmd_o.flag      = 1'b1;
            cmd_o.flag_code = ST_OVER;
          end else begin
            cmd_o.push = 1'b1;
          end
        end else if (sts_i.is_op) begin
          if (sts_i.lt2) begin
            cmd_o.flag      = 1'b1;
            cmd_o.flag_code = ST_UNDER;
          end else begin
            cmd_o.rd_req = 1'b1;
            state_d      = S_LOAD;
          end
        end else begin
          cmd_o.flag      = 1'b1;
          cmd_o.flag_code = ST_UNKNOWN;
        end
      end
      S_LOAD: begin
        state_d = S_FIN;
        if (sts_i.is_divop) begin
          if (sts_i.rhs_zero) begin
            cmd_o.flag      = 1'b1;
            cmd_o.flag_code = ST_DIVZ;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIVW;
          end
        end else begin
          cmd_o.alu_wr = 1'b1;
        end
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.div_wr = 1'b1;
          state_d      = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### design/postfix_stack_evaluator_core.sv
// Postfix expression evaluator: one character per input beat, one result beat per input
// beat carrying the top of stack, the sticky status and the end-of-expression flag.
// From acceptance, a digit passes decode and finish; an operator other than / and % passes
// decode, stack read and alu write-back; / or % pass decode, stack read, the radix-2 divider
// (32 steps) and write-back; underflow and unknown symbols end after decode, divide by zero
// after the stack read. The next input beat can be accepted in the cycle the result appears.
// A held result does not block the next input beat; it only delays the end of the following
// item. The operand stack lives in a memory below a top-of-stack register and needs no
// clearing after reset. depends on pse_pkg, pse_ctrl, pse_dpath

module postfix_stack_evaluator_core import pse_pkg::*; #(
  parameter int StackDepth = DefStackDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [SymW-1:0]  symbol_i,
  input  logic             last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] value_o,
  output logic [2:0]       status_o,
  output logic             done_res_o
);

  pse_cmd_t cmd;
  pse_sts_t sts;

  pse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pse_dpath #(
    .StackDepth (StackDepth)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .symbol_i   (symbol_i),
    .last_i     (last_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .value_o    (value_o),
    .status_o   (status_o),
    .done_res_o (done_res_o)
  );

  // an accepted beat is followed by work, never by another accept
  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while item in progress");

  // a new result beat only appears while an item is being finished
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without an item");

  // one stack update per cycle
  a_single_stack_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.push, cmd.alu_wr, cmd.div_wr}) <= 1)
    else $error("conflicting stack updates");

  // the divider never reports completion right after a start
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !sts.div_done)
    else $error("divider finished too early");

endmodule
